// ===== design/gbnsw_pkg.sv =====
// Package for the Go-Back-N sender window core.
// Holds field widths, event and register codes, item structs and control structs.
// No dependencies.
`default_nettype none

package gbnsw_pkg;

  localparam int SEQ_WIDTH      = 16;
  localparam int WIN_SIZE_W     = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int DEF_MAX_WINDOW = 16;

  localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RST     = 5'd4;
  localparam logic [SEQ_WIDTH-1:0]  TOTAL_FRAMES_RST = 16'd8;

  localparam logic [1:0] REQ_POLL    = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 1'd1;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [SEQ_WIDTH-1:0] ack_num;
  } in_item_t;

  typedef struct packed {
    logic                 frame_valid;
    logic [SEQ_WIDTH-1:0] seq_num;
    logic                 is_retransmit;
    logic                 ack_accepted;
    logic                 all_done;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic calc_limit;
    logic calc_count;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic final_item;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== design/gbnsw_ctrl.sv =====
// Controller state machine for the Go-Back-N sender window core.
// Sequences accept, two count stages and emission; depends on gbnsw_pkg.
`default_nettype none

module gbnsw_ctrl
  import gbnsw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        cmd.calc_limit = 1'b1;
        state_nxt      = ST_COUNT;
      end
      ST_COUNT: begin
        cmd.calc_count = 1'b1;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.final_item) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/gbnsw_dp.sv =====
// Datapath for the Go-Back-N sender window core.
// Holds configuration, window state, emission counters and the output register.
// Depends on gbnsw_pkg.
`default_nettype none

module gbnsw_dp
  import gbnsw_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  output ctrl_sts_t                  sts,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output out_item_t                  out_data
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int LW = SEQ_WIDTH + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WINDOW);

  logic [WIN_SIZE_W-1:0] win_size_r, win_size_nxt;
  logic [SEQ_WIDTH-1:0]  total_r, total_nxt;
  logic [SEQ_WIDTH-1:0]  base_r, base_nxt;
  logic [SEQ_WIDTH-1:0]  next_r, next_nxt;
  logic [CW-1:0]         retx_left_r, retx_left_nxt;
  logic [CW-1:0]         tot_left_r, tot_left_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [1:0]            req_r;
  logic                  ack_acc_r;
  logic                  done_r;
  logic [LW-1:0]         limit_r;
  logic [CW-1:0]         retx_cnt_r;
  logic [SEQ_WIDTH-1:0]  cur_r;
  out_item_t             out_r;

  logic                  ack_hit;
  logic                  done_c;
  logic [CW-1:0]         win_sat;
  logic [LW-1:0]         limit_sum;
  logic [LW-1:0]         limit_c;
  logic [SEQ_WIDTH-1:0]  outst;
  logic [CW-1:0]         retx_c;
  logic [LW-1:0]         avail;
  logic [CW-1:0]         room;
  logic [CW-1:0]         new_c;
  logic                  item_retx;
  out_item_t             item;

  assign ack_hit = (in_data.req_type == REQ_ACK) && (in_data.ack_num >= base_r) &&
                   (in_data.ack_num < next_r);

  always_comb begin
    done_c    = (base_r >= total_r);
    win_sat   = (32'(win_size_r) > 32'(MAX_WINDOW)) ? MAX_CNT : CW'(win_size_r);
    limit_sum = LW'(base_r) + LW'(win_sat);
    limit_c   = (limit_sum > LW'(total_r)) ? LW'(total_r) : limit_sum;
    outst     = next_r - base_r;
    if ((req_r == REQ_TIMEOUT) && !done_c) begin
      retx_c = (32'(outst) > 32'(MAX_WINDOW)) ? MAX_CNT : CW'(outst);
    end else begin
      retx_c = '0;
    end
  end

  always_comb begin
    if (!done_r && (limit_r > LW'(next_r))) begin
      avail = limit_r - LW'(next_r);
    end else begin
      avail = '0;
    end
    room  = MAX_CNT - retx_cnt_r;
    new_c = (avail > LW'(room)) ? room : CW'(avail);
  end

  always_comb begin
    item_retx          = (retx_left_r != '0);
    item.frame_valid   = (tot_left_r != '0);
    item.is_retransmit = item.frame_valid && item_retx;
    item.ack_accepted  = ack_acc_r;
    item.all_done      = done_r;
    item.last          = (tot_left_r <= CW'(1));
    if (!item.frame_valid) begin
      item.seq_num = '0;
    end else if (item_retx) begin
      item.seq_num = cur_r;
    end else begin
      item.seq_num = next_r;
    end
  end

  always_comb begin
    win_size_nxt  = win_size_r;
    total_nxt     = total_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    retx_left_nxt = retx_left_r;
    tot_left_nxt  = tot_left_r;
    out_valid_nxt = out_valid_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:  win_size_nxt = cfg_wdata[WIN_SIZE_W-1:0];
        CFG_TOTAL_FRAMES: total_nxt    = cfg_wdata[SEQ_WIDTH-1:0];
        default: ;
      endcase
    end
    if (cmd.accept && ack_hit) begin
      base_nxt = in_data.ack_num + SEQ_WIDTH'(1);
    end
    if (cmd.calc_count) begin
      retx_left_nxt = retx_cnt_r;
      tot_left_nxt  = retx_cnt_r + new_c;
    end
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (item.frame_valid) begin
        tot_left_nxt = tot_left_r - CW'(1);
        if (item_retx) begin
          retx_left_nxt = retx_left_r - CW'(1);
        end else begin
          next_nxt = next_r + SEQ_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r  <= WIN_SIZE_RST;
      total_r     <= TOTAL_FRAMES_RST;
      base_r      <= '0;
      next_r      <= '0;
      retx_left_r <= '0;
      tot_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_size_r  <= win_size_nxt;
      total_r     <= total_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      retx_left_r <= retx_left_nxt;
      tot_left_r  <= tot_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r     <= in_data.req_type;
      ack_acc_r <= ack_hit;
    end
    if (cmd.calc_limit) begin
      done_r     <= done_c;
      limit_r    <= limit_c;
      retx_cnt_r <= retx_c;
      cur_r      <= base_r;
    end
    if (cmd.emit) begin
      out_r <= item;
      if (item.frame_valid && item_retx) begin
        cur_r <= cur_r + SEQ_WIDTH'(1);
      end
    end
  end

  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.final_item = (tot_left_r <= CW'(1));
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

  // The window base never passes the next sequence number.
  a_base_le_next: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= next_r) else $error("window base passed next sequence");

  // Resends pending never exceed the items pending.
  a_retx_le_tot: assert property (@(posedge clk) disable iff (!rst_n)
    retx_left_r <= tot_left_r) else $error("resend count exceeds pending count");

  // No event produces more than a full window of results.
  a_tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tot_left_r <= MAX_CNT) else $error("pending count exceeds window limit");

  // A retransmitted item always names a frame.
  a_retx_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_retransmit) |-> out_r.frame_valid)
    else $error("retransmit flag on status item");

endmodule

`default_nettype wire

// ===== design/go_back_n_sender_window_core.sv =====
// Top level of the Go-Back-N sender window core.
// Instantiates gbnsw_ctrl and gbnsw_dp; depends on gbnsw_pkg.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    in_item_t (req_type, ack_num)
//   out_      output     out_valid/out_ready  out_item_t (frame_valid ... last)
//   cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// An event yields n results, n from 1 to MAX_WINDOW: the IDLE state accepts it and
// applies the ack, the LIMIT and COUNT states size the window, then EMIT puts one
// result per cycle into the output register while the output is not stalled.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled output holds the emitter; a new event is taken as soon as the
// last result of the previous one sits in the output register.
`default_nettype none

module go_back_n_sender_window_core
  import gbnsw_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  gbnsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbnsw_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
